// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; the enclosing module provides clk and rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SFP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/sfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Status frame parser package
// Shared constants, command item type and character class helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  localparam int LINE_MAX_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  // request codes on the input channel
  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_EOL  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // item kinds held in the queue
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_EOL  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // verdict codes
  localparam logic [3:0] ERR_OK     = 4'd0;
  localparam logic [3:0] ERR_HEADER = 4'd1;
  localparam logic [3:0] ERR_FIELDS = 4'd2;
  localparam logic [3:0] ERR_TEMP   = 4'd3;
  localparam logic [3:0] ERR_SET    = 4'd4;
  localparam logic [3:0] ERR_POWER  = 4'd5;
  localparam logic [3:0] ERR_RANGE  = 4'd6;
  localparam logic [3:0] ERR_MODE   = 4'd7;
  localparam logic [3:0] ERR_TRAIL  = 4'd8;

  localparam logic [7:0]  CH_COMMA = 8'h2C;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [16:0] MAG_CAP  = 17'h1FFFF;
  localparam logic [16:0] POWER_MAX = 17'd100;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [31:0] now_ms;
  } sfp_cmd_t;

  function automatic logic [7:0] hdr_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h24; // '$'
      2'd1:    ch = 8'h54; // 'T'
      default: ch = CH_COMMA;
    endcase
    return ch;
  endfunction

  function automatic logic is_mode(input logic [7:0] c);
    logic hit;
    case (c)
      8'h45, 8'h4F, 8'h53, 8'h42, 8'h57, 8'h48, 8'h4C: hit = 1'b1; // E O S B W H L
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

`default_nettype wire

// ===== sv/status_frame_parser.sv =====
// ---------------------------------------------------------------------------
// Status frame parser
// Streams "$T,temp,set,power,mode" lines and reports a verdict per line.
// Input items (in_valid/in_ready): req_type 0 is a line character, 1 ends the
// line, 2 asks for a time check, 3 is taken and dropped. A character gives no
// result; end of line and time check each give one on out_valid/out_ready.
// cfg_valid/cfg_ready writes online_timeout_ms; cfg_ready is high outside reset.
// Order: an item is written to the queue at its accepting edge, parsed from the
// head of the queue, and its result is registered into the output slot.
// Throughput: one item and one result per cycle while the queue has room and
// the result slot is free, set by the single parse step per cycle.
// Stall: while a result waits, characters ahead of the next end of line or time
// check are still parsed; that item waits at the head of the QUEUE_DEPTH-entry
// queue and in_ready drops once the queue is full.
// Reset: rst clears the line state, kept values, counters and last frame time
// and sets the timeout to 1000 ms; both input channels hold ready low and no
// result is pending.
// ---------------------------------------------------------------------------
`default_nettype none

module status_frame_parser import sfp_pkg::*; #(
  parameter int LINE_MAX    = LINE_MAX_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [7:0]         char_code,
  input  logic [31:0]        now_ms,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_frame_result,
  output logic [3:0]         error_code,
  output logic signed [15:0] current_temp,
  output logic signed [15:0] set_temp,
  output logic [6:0]         power_percent,
  output logic [7:0]         mode_letter,
  output logic [31:0]        lines_seen,
  output logic [31:0]        frames_valid,
  output logic [31:0]        frames_invalid,
  output logic               link_online
);

  logic     q_full;
  logic     q_push;
  sfp_cmd_t q_in;
  logic     q_pop;
  logic     q_not_empty;
  sfp_cmd_t q_out;

  assign cfg_ready = !rst;

  // nothing is taken while in reset
  sfp_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .char_code (char_code),
    .now_ms    (now_ms),
    .q_full    (q_full || rst),
    .push      (q_push),
    .push_cmd  (q_in)
  );

  sfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_out)
  );

  sfp_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (q_not_empty),
    .cmd             (q_out),
    .cmd_pop         (q_pop),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .is_frame_result (is_frame_result),
    .error_code      (error_code),
    .current_temp    (current_temp),
    .set_temp        (set_temp),
    .power_percent   (power_percent),
    .mode_letter     (mode_letter),
    .lines_seen      (lines_seen),
    .frames_valid    (frames_valid),
    .frames_invalid  (frames_invalid),
    .link_online     (link_online)
  );

endmodule

`default_nettype wire

// ===== sv/sfp_front.sv =====
// ---------------------------------------------------------------------------
// Status frame parser front end
// Takes items from the input channel, classifies them and loads the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module sfp_front import sfp_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_code,
  input  logic [31:0] now_ms,
  input  logic        q_full,
  output logic        push,
  output sfp_cmd_t    push_cmd
);

  logic       known;
  logic [1:0] kind;

  always_comb begin
    known = 1'b1;
    case (req_type)
      REQ_CHAR: kind = KIND_CHAR;
      REQ_EOL:  kind = KIND_EOL;
      REQ_TICK: kind = KIND_TICK;
      default: begin
        // unused request: taken and dropped
        kind  = KIND_CHAR;
        known = 1'b0;
      end
    endcase
  end

  assign in_ready           = !q_full;
  assign push               = in_valid && !q_full && known;
  assign push_cmd.kind      = kind;
  assign push_cmd.char_code = char_code;
  assign push_cmd.now_ms    = now_ms;

endmodule

`default_nettype wire

// ===== sv/sfp_queue.sv =====
// ---------------------------------------------------------------------------
// Status frame parser queue
// Short first-in first-out queue between the front end and the parser.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfp_queue import sfp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  sfp_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output sfp_cmd_t pop_cmd
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sfp_cmd_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SFP_NEVER(a_q_overflow, count > CW'(DEPTH), "queue count beyond depth")
  `SFP_NEVER(a_q_underflow, pop && count == '0, "pop from empty queue")
  `SFP_ASSERT(a_q_grow, push && !pop |=> count == $past(count) + 1'b1, "push lost")

endmodule

`default_nettype wire

// ===== sv/sfp_back.sv =====
// ---------------------------------------------------------------------------
// Status frame parser back end
// Runs the line parser, keeps values and counters, and holds the result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfp_back import sfp_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  sfp_cmd_t           cmd,
  output logic               cmd_pop,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_frame_result,
  output logic [3:0]         error_code,
  output logic signed [15:0] current_temp,
  output logic signed [15:0] set_temp,
  output logic [6:0]         power_percent,
  output logic [7:0]         mode_letter,
  output logic [31:0]        lines_seen,
  output logic [31:0]        frames_valid,
  output logic [31:0]        frames_invalid,
  output logic               link_online
);

  localparam int PW = $clog2(LINE_MAX);
  localparam logic [PW-1:0] POS_LAST = PW'(LINE_MAX - 1);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_DIGIT  = 3'd3;
  localparam logic [2:0] PH_MODE   = 3'd4;
  localparam logic [2:0] PH_TAIL   = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  // line parse state
  logic [2:0]    phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [2:0]    commas, commas_next;
  logic [16:0]   mag, mag_next;
  logic          neg, neg_next;
  logic          dseen, dseen_next;
  logic [3:0]    ferr, ferr_next;
  logic          ended, ended_next;
  logic [15:0]   pend_temp, pend_temp_next;
  logic [15:0]   pend_set, pend_set_next;
  logic [6:0]    pend_power, pend_power_next;
  logic [7:0]    pend_mode, pend_mode_next;

  // kept state
  logic [31:0]   timeout;
  logic [31:0]   lvt;

  logic          slot_free;
  logic          take_char;
  logic          take_eol;
  logic          take_tick;
  logic [3:0]    verdict;
  logic [31:0]   lvt_eff;
  logic [31:0]   age;
  logic          online;

  logic          fail;
  logic [3:0]    fail_code;
  logic [7:0]    c;
  logic [1:0]    fld;
  logic [3:0]    num_err;
  logic [20:0]   acc;
  logic [16:0]   mag_acc;
  logic [16:0]   limit;
  logic [15:0]   val16;

  assign slot_free = !out_valid || out_ready;
  assign cmd_pop   = cmd_valid && ((cmd.kind == KIND_CHAR) || slot_free);
  assign take_char = cmd_pop && (cmd.kind == KIND_CHAR);
  assign take_eol  = cmd_pop && (cmd.kind == KIND_EOL);
  assign take_tick = cmd_pop && (cmd.kind == KIND_TICK);

  // one character step
  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    commas_next     = commas;
    mag_next        = mag;
    neg_next        = neg;
    dseen_next      = dseen;
    ferr_next       = ferr;
    ended_next      = ended;
    pend_temp_next  = pend_temp;
    pend_set_next   = pend_set;
    pend_power_next = pend_power;
    pend_mode_next  = pend_mode;
    fail            = 1'b0;
    fail_code       = ERR_OK;
    c               = cmd.char_code;

    // field index follows the commas seen before this character
    fld     = (commas >= 3'd1 && commas <= 3'd3) ? 2'(commas - 3'd1) : 2'd2;
    num_err = ERR_TEMP + {2'b00, fld};
    acc     = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {17'd0, c[3:0]};
    mag_acc = (acc[20:17] != 4'd0) ? MAG_CAP : acc[16:0];
    limit   = neg ? 17'd32768 : 17'd32767;
    val16   = neg ? (16'd0 - mag[15:0]) : mag[15:0];

    if (!ended && pos < POS_LAST) begin
      pos_next = pos + 1'b1;
      if (c == 8'h00) begin
        ended_next = 1'b1;
      end else begin
        if (c == CH_COMMA && commas != 3'd7) begin
          commas_next = commas + 1'b1;
        end
        case (phase)
          PH_HEADER: begin
            if (pos > PW'(2) || c != hdr_char(pos[1:0])) begin
              fail      = 1'b1;
              fail_code = ERR_HEADER;
            end else if (pos == PW'(2)) begin
              phase_next = PH_LEAD;
              mag_next   = '0;
              neg_next   = 1'b0;
              dseen_next = 1'b0;
            end
          end
          PH_LEAD: begin
            if (is_blank(c)) begin
              phase_next = PH_LEAD;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              neg_next   = (c == CH_MINUS);
              phase_next = PH_SIGN;
            end else if (is_digit(c)) begin
              mag_next   = mag_acc;
              dseen_next = 1'b1;
              phase_next = PH_DIGIT;
            end else begin
              fail      = 1'b1;
              fail_code = num_err;
            end
          end
          PH_SIGN: begin
            if (is_digit(c)) begin
              mag_next   = mag_acc;
              dseen_next = 1'b1;
              phase_next = PH_DIGIT;
            end else begin
              fail      = 1'b1;
              fail_code = num_err;
            end
          end
          PH_DIGIT: begin
            if (is_digit(c)) begin
              mag_next   = mag_acc;
              dseen_next = 1'b1;
            end else if (c == CH_COMMA) begin
              if (!dseen || mag > limit) begin
                fail      = 1'b1;
                fail_code = num_err;
              end else begin
                case (fld)
                  2'd0:    pend_temp_next  = val16;
                  2'd1:    pend_set_next   = val16;
                  default: pend_power_next = val16[6:0];
                endcase
                mag_next   = '0;
                neg_next   = 1'b0;
                dseen_next = 1'b0;
                if (fld != 2'd2) begin
                  phase_next = PH_LEAD;
                end else if ((neg && mag != '0) || (!neg && mag > POWER_MAX)) begin
                  fail      = 1'b1;
                  fail_code = ERR_RANGE;
                end else begin
                  phase_next = PH_MODE;
                end
              end
            end else begin
              fail      = 1'b1;
              fail_code = num_err;
            end
          end
          PH_MODE: begin
            if (is_mode(c)) begin
              pend_mode_next = c;
              phase_next     = PH_TAIL;
            end else begin
              fail      = 1'b1;
              fail_code = ERR_MODE;
            end
          end
          PH_TAIL: begin
            fail      = 1'b1;
            fail_code = ERR_TRAIL;
          end
          default: begin
            phase_next = phase;
          end
        endcase
        if (fail) begin
          if (ferr == ERR_OK) begin
            ferr_next = fail_code;
          end
          phase_next = PH_SKIP;
        end
      end
    end
  end

  // end of line verdict, header first, then field count, then first error, then missing mode
  always_comb begin
    if (phase == PH_HEADER || ferr == ERR_HEADER) begin
      verdict = ERR_HEADER;
    end else if (commas != 3'd4) begin
      verdict = ERR_FIELDS;
    end else if (ferr != ERR_OK) begin
      verdict = ferr;
    end else if (phase == PH_MODE) begin
      verdict = ERR_MODE;
    end else begin
      verdict = ERR_OK;
    end
  end

  // a valid frame refreshes the time stamp before the online check
  assign lvt_eff = (take_eol && verdict == ERR_OK) ? cmd.now_ms : lvt;
  assign age     = cmd.now_ms - lvt_eff;
  assign online  = (lvt_eff != 32'd0) && (age <= timeout);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      pos            <= '0;
      commas         <= '0;
      mag            <= '0;
      neg            <= 1'b0;
      dseen          <= 1'b0;
      ferr           <= ERR_OK;
      ended          <= 1'b0;
      timeout        <= TIMEOUT_RESET;
      lvt            <= '0;
      current_temp   <= '0;
      set_temp       <= '0;
      power_percent  <= '0;
      mode_letter    <= '0;
      lines_seen     <= '0;
      frames_valid   <= '0;
      frames_invalid <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        timeout <= cfg_data;
      end
      if (take_char) begin
        phase  <= phase_next;
        pos    <= pos_next;
        commas <= commas_next;
        mag    <= mag_next;
        neg    <= neg_next;
        dseen  <= dseen_next;
        ferr   <= ferr_next;
        ended  <= ended_next;
      end else if (take_eol) begin
        phase      <= PH_HEADER;
        pos        <= '0;
        commas     <= '0;
        mag        <= '0;
        neg        <= 1'b0;
        dseen      <= 1'b0;
        ferr       <= ERR_OK;
        ended      <= 1'b0;
        lines_seen <= lines_seen + 1'b1;
        if (verdict == ERR_OK) begin
          frames_valid  <= frames_valid + 1'b1;
          current_temp  <= pend_temp;
          set_temp      <= pend_set;
          power_percent <= pend_power;
          mode_letter   <= pend_mode;
          lvt           <= cmd.now_ms;
        end else begin
          frames_invalid <= frames_invalid + 1'b1;
        end
      end
      if (take_eol || take_tick) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending values and result payload
  always_ff @(posedge clk) begin
    if (take_char) begin
      pend_temp  <= pend_temp_next;
      pend_set   <= pend_set_next;
      pend_power <= pend_power_next;
      pend_mode  <= pend_mode_next;
    end
    if (take_eol || take_tick) begin
      is_frame_result <= take_eol;
      error_code      <= take_eol ? verdict : ERR_OK;
      link_online     <= online;
    end
  end

  `SFP_NEVER(a_err_code, out_valid && error_code > ERR_TRAIL, "error code out of range")
  `SFP_NEVER(a_tick_code, out_valid && !is_frame_result && error_code != ERR_OK, "tick error")
  `SFP_ASSERT(a_line_sum, lines_seen == frames_valid + frames_invalid, "line counters disagree")
  `SFP_NEVER(a_no_overrun, out_valid && !out_ready && (take_eol || take_tick), "result overrun")

endmodule

`default_nettype wire
